// ===== sv/qni_pkg.sv =====
// ----------------------------------------------------------------------------
// qni_pkg
// Shared widths and register codes of the quadtree node index unit.
// ----------------------------------------------------------------------------
package qni_pkg;

  localparam int LEVEL_W  = 4;
  localparam int SECTOR_W = 8;
  localparam int COORD_W  = 16;
  localparam int COUNT_W  = 9;
  localparam int INDEX_W  = 32;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  // register index (paddr[3:2])
  localparam logic [1:0] REG_MAX_LEVEL = 2'd0;
  localparam logic [1:0] REG_SECTORS_X = 2'd1;
  localparam logic [1:0] REG_SECTORS_Z = 2'd2;

endpackage

// ===== sv/qni_req_if.sv =====
// ----------------------------------------------------------------------------
// qni_req_if
// Request channel: one node lookup word per handshake.
// ----------------------------------------------------------------------------
interface qni_req_if import qni_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [LEVEL_W-1:0]  level;
  logic [SECTOR_W-1:0] sector_x;
  logic [SECTOR_W-1:0] sector_z;
  logic [COORD_W-1:0]  coord_x;
  logic [COORD_W-1:0]  coord_z;

  modport source (output valid, command, level, sector_x, sector_z, coord_x, coord_z,
                  input ready);
  modport sink   (input valid, command, level, sector_x, sector_z, coord_x, coord_z,
                  output ready);
endinterface

// ===== sv/qni_rsp_if.sv =====
// ----------------------------------------------------------------------------
// qni_rsp_if
// Response channel: one slot word per handshake.
// ----------------------------------------------------------------------------
interface qni_rsp_if import qni_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [INDEX_W-1:0] node_index;

  modport source (output valid, valid_res, node_index, input ready);
  modport sink   (input valid, valid_res, node_index, output ready);
endinterface

// ===== sv/quadtree_node_index_unit.sv =====
// ----------------------------------------------------------------------------
// quadtree_node_index_unit
// Linear slot of a quadtree node in a sector-major, level-major node table.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | word
//  req_i   | in  | valid / ready       | command, level, sector_x/z, coord_x/z
//  rsp_o   | out | valid / ready       | valid_res, node_index
//  apb     | in  | psel/penable/pready | max_level, sectors_x, sectors_z
//
//  Four register stages: range check and level offsets, sector index
//  multiply-add, sector base multiply, final add with overflow check.
//  One word is taken every cycle when rsp_o is not stalled.
//  Each stage holds its word while the next one is full and stalled, so a stall backs up
//  stage by stage and bubbles are squeezed out.
//  Reset clears all stage valid bits and loads max_level 0, sectors 1 x 1.
// ----------------------------------------------------------------------------
module quadtree_node_index_unit import qni_pkg::*; #(
  parameter int LEVEL_LIMIT  = 8,
  parameter int SECTOR_LIMIT = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  qni_req_if.sink           req_i,
  qni_rsp_if.source         rsp_o
);

  localparam int LW    = LEVEL_LIMIT;          // local coordinate bits
  localparam int PW    = 2 * LEVEL_LIMIT;      // per-sector count / offset bits
  localparam int SIW   = 18;                   // sector index bits
  localparam int PRW   = SIW + PW;
  localparam int SUMW  = (PRW + 1 > INDEX_W + 1) ? PRW + 1 : INDEX_W + 1;
  localparam int CAP   = (SECTOR_LIMIT > 511) ? 511 : SECTOR_LIMIT;
  localparam logic [COUNT_W-1:0] CAP_V = COUNT_W'(CAP);

  // (4^n - 1) / 3: n ones on even bit positions
  function automatic logic [PW-1:0] gsum(input logic [LEVEL_W:0] n);
    logic [PW-1:0] r;
    r = '0;
    for (int i = 0; i < PW / 2; i++) begin
      r[2*i] = (i < int'(n));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic [LEVEL_W-1:0] max_level_q;
  logic [COUNT_W-1:0] sectors_x_q, sectors_z_q;
  logic               cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= '0;
      sectors_x_q <= COUNT_W'(1);
      sectors_z_q <= COUNT_W'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MAX_LEVEL: max_level_q <= pwdata[LEVEL_W-1:0];
        REG_SECTORS_X: sectors_x_q <= pwdata[COUNT_W-1:0];
        REG_SECTORS_Z: sectors_z_q <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_LEVEL: prdata = APB_DW'(max_level_q);
      REG_SECTORS_X: prdata = APB_DW'(sectors_x_q);
      REG_SECTORS_Z: prdata = APB_DW'(sectors_z_q);
      default:       prdata = '0;
    endcase
  end

  logic [COUNT_W-1:0] nx, nz;
  assign nx = (sectors_x_q > CAP_V) ? CAP_V : sectors_x_q;
  assign nz = (sectors_z_q > CAP_V) ? CAP_V : sectors_z_q;

  // ---------------------------------------------------------------- flow
  logic va_q, vb_q, vc_q, vd_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  assign rdy_d = !vd_q || rsp_o.ready;
  assign rdy_c = !vc_q || rdy_d;
  assign rdy_b = !vb_q || rdy_c;
  assign rdy_a = !va_q || rdy_b;
  assign req_i.ready = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= req_i.valid;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
    end
  end

  // ---------------------------------------------------------------- stage A
  logic [LEVEL_W-1:0]  d;
  logic [COORD_W-1:0]  smask, sx_e, sz_e, lx_e, lz_e;
  logic                lvl_ok, loc_ok, sec_ok;
  logic [PW-1:0]       per_a, off_a, loc_a;

  assign lvl_ok = (int'(max_level_q) < LEVEL_LIMIT) && (req_i.level <= max_level_q);
  assign d      = max_level_q - req_i.level;
  assign smask  = ~({COORD_W{1'b1}} << d);
  assign lx_e   = req_i.coord_x & smask;
  assign lz_e   = req_i.coord_z & smask;
  assign sx_e   = req_i.command ? (req_i.coord_x >> d) : COORD_W'(req_i.sector_x);
  assign sz_e   = req_i.command ? (req_i.coord_z >> d) : COORD_W'(req_i.sector_z);
  // sector mode: local coordinate must already lie inside the side
  assign loc_ok = req_i.command ||
                  (((req_i.coord_x & ~smask) == '0) && ((req_i.coord_z & ~smask) == '0));
  assign sec_ok = (sx_e < COORD_W'(nx)) && (sz_e < COORD_W'(nz));

  assign per_a = gsum({1'b0, max_level_q} + 5'd1);
  assign off_a = per_a - gsum({1'b0, d} + 5'd1);
  assign loc_a = ({{LW{1'b0}}, lz_e[LW-1:0]} << d) | {{LW{1'b0}}, lx_e[LW-1:0]};

  logic                ok_a_q;
  logic [COUNT_W-1:0]  sx_a_q, sz_a_q;
  logic [PW-1:0]       per_a_q, off_a_q, loc_a_q;

  always_ff @(posedge clk_i) begin
    if (rdy_a && req_i.valid) begin
      ok_a_q  <= lvl_ok && loc_ok && sec_ok;
      sx_a_q  <= sx_e[COUNT_W-1:0];
      sz_a_q  <= sz_e[COUNT_W-1:0];
      per_a_q <= per_a;
      off_a_q <= off_a;
      loc_a_q <= loc_a;
    end
  end

  // ---------------------------------------------------------------- stage B
  logic          ok_b_q;
  logic [SIW-1:0] sidx_b_q;
  logic [PW-1:0]  per_b_q, offl_b_q;

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      ok_b_q   <= ok_a_q;
      sidx_b_q <= SIW'(sz_a_q) * SIW'(nx) + SIW'(sx_a_q);
      per_b_q  <= per_a_q;
      offl_b_q <= off_a_q + loc_a_q;   // stays below per_sector
    end
  end

  // ---------------------------------------------------------------- stage C
  logic           ok_c_q;
  logic [PRW-1:0] base_c_q;
  logic [PW-1:0]  offl_c_q;

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      ok_c_q   <= ok_b_q;
      base_c_q <= PRW'(sidx_b_q) * PRW'(per_b_q);
      offl_c_q <= offl_b_q;
    end
  end

  // ---------------------------------------------------------------- stage D
  logic [SUMW-1:0]    slot;
  logic               fit;
  logic               res_d_q;
  logic [INDEX_W-1:0] idx_d_q;

  assign slot = SUMW'(base_c_q) + SUMW'(offl_c_q);
  assign fit  = (slot[SUMW-1:INDEX_W] == '0);

  always_ff @(posedge clk_i) begin
    if (rdy_d && vc_q) begin
      res_d_q <= ok_c_q && fit;
      idx_d_q <= (ok_c_q && fit) ? slot[INDEX_W-1:0] : '0;
    end
  end

  assign rsp_o.valid      = vd_q;
  assign rsp_o.valid_res  = res_d_q;
  assign rsp_o.node_index = idx_d_q;

  // ---------------------------------------------------------------- checks
  a_take_fills_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> va_q)
    else $error("accepted request did not land in stage A");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q && vb_q && vc_q && vd_q && !rsp_o.ready) |-> !req_i.ready)
    else $error("request taken while pipeline is full and stalled");

  a_ok_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (va_q && ok_a_q) |-> (int'(max_level_q) < LEVEL_LIMIT))
    else $error("stage A marked valid with max_level out of range");

  a_zero_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.valid_res) |-> (rsp_o.node_index == '0))
    else $error("invalid result carries nonzero index");

endmodule
